FILE: rtl/ashm_pkg.sv
// Shared types, register codes and helper functions for the accelerometer
// sample health monitor.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package ashm_pkg;

	localparam int unsigned AXES       = 3;
	localparam int unsigned SAMPLE_W   = 12;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned MAG_W      = SAMPLE_W + 1;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [COUNT_W-1:0]  COUNT_MAX             = '1;
	localparam logic [COUNT_W-1:0]  STUCK_LIMIT_RESET     = 16'd96;
	localparam logic [COUNT_W-1:0]  OVERRANGE_LIMIT_RESET = 16'd160;
	localparam logic [SAMPLE_W-1:0] MAGNITUDE_LIMIT_RESET = 12'd665;

	// Register index, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_SLEEPING        = 2'd0,
		REG_STUCK_LIMIT     = 2'd1,
		REG_OVERRANGE_LIMIT = 2'd2,
		REG_MAGNITUDE_LIMIT = 2'd3
	} reg_idx_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]  count_t;

	// Configuration registers as seen by the evaluation logic.
	typedef struct packed {
		logic                sleeping;
		logic [COUNT_W-1:0]  stuck_limit;
		logic [COUNT_W-1:0]  overrange_limit;
		logic [SAMPLE_W-1:0] magnitude_limit;
	} cfg_t;

	// One three-axis sample.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_z;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_x;
	} sample_in_t;

	// Verdict for one sample.
	typedef struct packed {
		logic overrange_fault;
		logic stuck_fault;
		logic fault;
	} result_t;

	// Increment that holds at the top instead of wrapping.
	function automatic count_t sat_inc(input count_t c);
		return (c == COUNT_MAX) ? COUNT_MAX : count_t'(c + 1'b1);
	endfunction

	// Magnitude of a two's complement sample; the most negative value gives 2048.
	function automatic logic [MAG_W-1:0] mag_of(input sample_t v);
		logic [MAG_W-1:0] ext;
		ext = {v[SAMPLE_W-1], v};
		return v[SAMPLE_W-1] ? MAG_W'(~ext + 1'b1) : ext;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ashm_cfg.sv
// APB configuration registers of the accelerometer sample health monitor.
// Depends on ashm_pkg for the register codes, reset values and cfg_t.
`default_nettype none

module ashm_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ashm_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [ashm_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [ashm_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output ashm_pkg::cfg_t                       cfg
);

	ashm_pkg::cfg_t     cfg_q;
	ashm_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = ashm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sleeping        <= 1'b0;
			cfg_q.stuck_limit     <= ashm_pkg::STUCK_LIMIT_RESET;
			cfg_q.overrange_limit <= ashm_pkg::OVERRANGE_LIMIT_RESET;
			cfg_q.magnitude_limit <= ashm_pkg::MAGNITUDE_LIMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				ashm_pkg::REG_SLEEPING:        cfg_q.sleeping <= pwdata[0];
				ashm_pkg::REG_STUCK_LIMIT:     cfg_q.stuck_limit <= pwdata[15:0];
				ashm_pkg::REG_OVERRANGE_LIMIT: cfg_q.overrange_limit <= pwdata[15:0];
				ashm_pkg::REG_MAGNITUDE_LIMIT: cfg_q.magnitude_limit <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		prdata = '0;
		case (idx)
			ashm_pkg::REG_SLEEPING:        prdata[0] = cfg_q.sleeping;
			ashm_pkg::REG_STUCK_LIMIT:     prdata[15:0] = cfg_q.stuck_limit;
			ashm_pkg::REG_OVERRANGE_LIMIT: prdata[15:0] = cfg_q.overrange_limit;
			ashm_pkg::REG_MAGNITUDE_LIMIT: prdata[11:0] = cfg_q.magnitude_limit;
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/ashm_eval.sv
// Per-sample evaluation: stuck and over-range checks with their per-axis state.
// Depends on ashm_pkg; the state registers update when update_en is high.
`default_nettype none

module ashm_eval (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ashm_pkg::cfg_t      cfg,
	input  wire logic                update_en,
	input  wire ashm_pkg::sample_in_t sample,
	output ashm_pkg::result_t        result
);

	ashm_pkg::sample_t prev_q      [ashm_pkg::AXES];
	ashm_pkg::count_t  same_cnt_q  [ashm_pkg::AXES];
	ashm_pkg::count_t  over_cnt_q  [ashm_pkg::AXES];

	ashm_pkg::sample_t prev_d      [ashm_pkg::AXES];
	ashm_pkg::count_t  same_cnt_d  [ashm_pkg::AXES];
	ashm_pkg::count_t  over_cnt_d  [ashm_pkg::AXES];
	ashm_pkg::count_t  same_inc    [ashm_pkg::AXES];
	ashm_pkg::count_t  over_inc    [ashm_pkg::AXES];

	ashm_pkg::sample_t         s  [ashm_pkg::AXES];
	logic [ashm_pkg::AXES-1:0] eq;
	logic [ashm_pkg::AXES-1:0] ov;
	logic [ashm_pkg::AXES-1:0] same_hit;
	logic [ashm_pkg::AXES-1:0] over_hit;
	logic                      any_eq;
	logic                      all_zero;
	logic                      any_ov;
	logic                      stuck;
	logic                      over;

	assign s[0] = sample.accel_x;
	assign s[1] = sample.accel_y;
	assign s[2] = sample.accel_z;

	// Per-axis compares against the stored value and the magnitude limit.
	always_comb begin
		for (int i = 0; i < ashm_pkg::AXES; i++) begin
			eq[i] = (s[i] == prev_q[i]);
			ov[i] = (ashm_pkg::mag_of(s[i]) >= {1'b0, cfg.magnitude_limit});
		end
	end

	assign any_eq   = |eq;
	assign any_ov   = |ov;
	assign all_zero = (s[0] == '0) && (s[1] == '0) && (s[2] == '0);

	// Stuck check: an equal axis counts once, an all-zero sample once more.
	always_comb begin
		ashm_pkg::count_t c1;
		for (int i = 0; i < ashm_pkg::AXES; i++) begin
			c1          = eq[i] ? ashm_pkg::sat_inc(same_cnt_q[i]) : same_cnt_q[i];
			same_inc[i] = all_zero ? ashm_pkg::sat_inc(c1) : c1;
			same_hit[i] = (same_inc[i] >= cfg.stuck_limit);
		end
	end

	assign stuck = any_eq && (|same_hit);

	// Over-range check: over axes count up, all others clear.
	always_comb begin
		for (int i = 0; i < ashm_pkg::AXES; i++) begin
			over_inc[i] = (any_ov && ov[i]) ? ashm_pkg::sat_inc(over_cnt_q[i]) : '0;
			over_hit[i] = (over_inc[i] >= cfg.overrange_limit);
		end
	end

	assign over = !stuck && any_ov && (|over_hit);

	// Next state; sleeping leaves everything as it is.
	always_comb begin
		for (int i = 0; i < ashm_pkg::AXES; i++) begin
			prev_d[i]     = prev_q[i];
			same_cnt_d[i] = same_cnt_q[i];
			over_cnt_d[i] = over_cnt_q[i];
			if (!cfg.sleeping) begin
				if (any_eq) begin
					same_cnt_d[i] = same_inc[i];
				end else begin
					prev_d[i]     = s[i];
					same_cnt_d[i] = '0;
				end
				if (!stuck) begin
					over_cnt_d[i] = over_inc[i];
				end
			end
		end
	end

	// Per-axis state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ashm_pkg::AXES; i++) begin
				prev_q[i]     <= '0;
				same_cnt_q[i] <= '0;
				over_cnt_q[i] <= '0;
			end
		end else if (update_en) begin
			for (int i = 0; i < ashm_pkg::AXES; i++) begin
				prev_q[i]     <= prev_d[i];
				same_cnt_q[i] <= same_cnt_d[i];
				over_cnt_q[i] <= over_cnt_d[i];
			end
		end
	end

	// Verdict; all zero while sleeping.
	always_comb begin
		result.stuck_fault     = !cfg.sleeping && stuck;
		result.overrange_fault = !cfg.sleeping && over;
		result.fault           = result.stuck_fault || result.overrange_fault;
	end

endmodule

`default_nettype wire

FILE: rtl/accel_sample_health_monitor_core.sv
// Top level of the accelerometer sample health monitor: stream ports, input
// and result registers, APB configuration. Uses ashm_pkg, ashm_cfg, ashm_eval.
`default_nettype none

// The monitor takes one three-axis sample per request on the s_ side and
// returns one verdict per sample on the m_ side, in order. A sample is held in
// an input register, evaluated against the per-axis stuck and over-range
// counters combinationally, and the verdict lands in a result register; the
// counters update on that same edge, so a new sample can be taken every cycle
// and a verdict leaves after the input and result registers. Throughput is
// one sample per cycle while m_tready stays high. Limits and the sleep bit are
// set through the APB port and should only change while no sample is in flight.
module accel_sample_health_monitor_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Sample stream.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// s_tdata: [11:0] accel_x, [23:12] accel_y, [35:24] accel_z, [39:36] zero
	input  wire logic [ashm_pkg::IN_DATA_W-1:0]   s_tdata,
	// Verdict stream.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata: [0] fault, [1] stuck_fault, [2] overrange_fault, [7:3] zero
	output logic      [ashm_pkg::OUT_DATA_W-1:0]  m_tdata,
	// Configuration.
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ashm_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [ashm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [ashm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);

	ashm_pkg::cfg_t       cfg;
	ashm_pkg::sample_in_t sample_s1;
	logic                 valid_s1;
	ashm_pkg::result_t    result;
	ashm_pkg::result_t    result_s2;
	logic                 valid_s2;
	logic                 adv_s2;
	logic                 adv_s1;

	// Stage 2 takes a new verdict when empty or being drained.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	ashm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= ashm_pkg::sample_in_t'(s_tdata[3*ashm_pkg::SAMPLE_W-1:0]);
		end
	end

	ashm_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.update_en (adv_s1),
		.sample    (sample_s1),
		.result    (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(ashm_pkg::OUT_DATA_W - 3)'(0), result_s2};

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for accel_sample_health_monitor_core: directed and random
// samples checked against an in-bench stuck/over-range model.
// Depends on ashm_pkg and the core RTL only.
module tb;

	localparam int REPORT_CAP = 200;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [ashm_pkg::IN_DATA_W-1:0]    s_tdata = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [ashm_pkg::OUT_DATA_W-1:0]   m_tdata;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [ashm_pkg::ADDR_W-1:0]       paddr = '0;
	logic [ashm_pkg::APB_DATA_W-1:0]   pwdata = '0;
	logic [ashm_pkg::APB_DATA_W-1:0]   prdata;
	logic                              pready;

	// Bench copy of the configuration and of the per-axis health state.
	ashm_pkg::cfg_t       cfg_shadow;
	ashm_pkg::sample_t    prev_smp [ashm_pkg::AXES];
	ashm_pkg::count_t     same_cnt [ashm_pkg::AXES];
	ashm_pkg::count_t     over_cnt [ashm_pkg::AXES];

	// Samples waiting to be sent and verdicts waiting to come back.
	ashm_pkg::sample_in_t sample_q [$];
	ashm_pkg::result_t    verdict_q [$];

	// Stimulus shaping: generator-side view of the stored previous sample.
	ashm_pkg::sample_t    gen_prev [ashm_pkg::AXES];
	int         hold_pct = 25;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         bad_cnt = 0;
	string      verdict_field [3] = '{"fault", "stuck_fault", "overrange_fault"};

	accel_sample_health_monitor_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Counter increment that holds at all ones.
	function automatic ashm_pkg::count_t count_up(input ashm_pkg::count_t c);
		return (c == 16'hFFFF) ? c : c + 16'd1;
	endfunction

	function automatic ashm_pkg::sample_in_t mk(input ashm_pkg::sample_t x,
			input ashm_pkg::sample_t y, input ashm_pkg::sample_t z);
		return '{accel_z: z, accel_y: y, accel_x: x};
	endfunction

	// Expected verdict for one accepted sample; updates the bench state.
	function automatic ashm_pkg::result_t judge_sample(input ashm_pkg::sample_in_t smp);
		ashm_pkg::sample_t ax [ashm_pkg::AXES];
		logic    eq [ashm_pkg::AXES];
		logic    ov [ashm_pkg::AXES];
		logic    any_eq;
		logic    all_zero;
		logic    any_ov;
		ashm_pkg::result_t r;
		int      i;
		int      mag;
		ax[0] = smp.accel_x;
		ax[1] = smp.accel_y;
		ax[2] = smp.accel_z;
		r = '0;
		any_eq = 1'b0;
		all_zero = 1'b1;
		any_ov = 1'b0;
		if (cfg_shadow.sleeping)
			return r;
		for (i = 0; i < ashm_pkg::AXES; i++) begin
			eq[i] = (ax[i] == prev_smp[i]);
			any_eq |= eq[i];
			if (ax[i] != '0)
				all_zero = 1'b0;
		end
		// Stuck check: count repeats, or take the new sample as reference.
		if (any_eq) begin
			for (i = 0; i < ashm_pkg::AXES; i++) begin
				if (eq[i])
					same_cnt[i] = count_up(same_cnt[i]);
				if (all_zero)
					same_cnt[i] = count_up(same_cnt[i]);
				if (same_cnt[i] >= cfg_shadow.stuck_limit)
					r.stuck_fault = 1'b1;
			end
		end else begin
			for (i = 0; i < ashm_pkg::AXES; i++) begin
				prev_smp[i] = ax[i];
				same_cnt[i] = '0;
			end
		end
		// Over-range check runs only without a stuck fault.
		if (!r.stuck_fault) begin
			for (i = 0; i < ashm_pkg::AXES; i++) begin
				mag = ax[i][ashm_pkg::SAMPLE_W-1] ? 4096 - int'(ax[i]) : int'(ax[i]);
				ov[i] = (mag >= int'(cfg_shadow.magnitude_limit));
				any_ov |= ov[i];
			end
			for (i = 0; i < ashm_pkg::AXES; i++) begin
				over_cnt[i] = (any_ov && ov[i]) ? count_up(over_cnt[i]) : '0;
				if (any_ov && over_cnt[i] >= cfg_shadow.overrange_limit)
					r.overrange_fault = 1'b1;
			end
		end
		r.fault = r.stuck_fault | r.overrange_fault;
		return r;
	endfunction

	// Random sample: repeats of the reference value, large magnitudes, zeros,
	// corner codes and fully random values.
	function automatic ashm_pkg::sample_in_t draw_sample();
		ashm_pkg::sample_t ax [ashm_pkg::AXES];
		int      i;
		int      m;
		int      lo;
		int      pick;
		logic    any_eq;
		pick = $urandom_range(99);
		lo = (cfg_shadow.magnitude_limit > 12'd2048) ? 2048 :
			int'(cfg_shadow.magnitude_limit);
		any_eq = 1'b0;
		for (i = 0; i < ashm_pkg::AXES; i++) begin
			if (pick < 8)
				ax[i] = '0;
			else if (pick < 13 || $urandom_range(99) < hold_pct)
				ax[i] = gen_prev[i];
			else begin
				case ($urandom_range(7))
					0, 1, 2: begin
						m = $urandom_range(2048, lo);
						ax[i] = ($urandom_range(1) || m == 2048) ?
							ashm_pkg::sample_t'(-m) : ashm_pkg::sample_t'(m);
					end
					3: ax[i] = '0;
					4: begin
						case ($urandom_range(3))
							0: ax[i] = 12'h800;
							1: ax[i] = 12'h7FF;
							2: ax[i] = 12'hFFF;
							default: ax[i] = 12'h001;
						endcase
					end
					default: ax[i] = ashm_pkg::sample_t'($urandom_range(4095));
				endcase
			end
			any_eq |= (ax[i] == gen_prev[i]);
		end
		if (!any_eq)
			for (i = 0; i < ashm_pkg::AXES; i++)
				gen_prev[i] = ax[i];
		return mk(ax[0], ax[1], ax[2]);
	endfunction

	// Sample driver: predicts on acceptance, then offers the next queued sample.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				verdict_q.push_back(judge_sample(
					ashm_pkg::sample_in_t'(s_tdata[3*ashm_pkg::SAMPLE_W-1:0])));
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= ashm_pkg::IN_DATA_W'(sample_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Verdict monitor: compares each accepted verdict with the oldest expected one.
	always @(posedge clk or negedge arst_n) begin : mon
		ashm_pkg::result_t want;
		int      k;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= REPORT_CAP)
						$display("%0t: verdict expected none actual %0h", $time, m_tdata);
				end else begin
					want = verdict_q.pop_front();
					for (k = 0; k < 3; k++) begin
						if (want[k] !== m_tdata[k]) begin
							bad_cnt++;
							if (bad_cnt <= REPORT_CAP)
								$display("%0t: %s expected %0b actual %0b", $time,
									verdict_field[k], want[k], m_tdata[k]);
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_xfer(input logic wr, input ashm_pkg::reg_idx_t idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_check(input ashm_pkg::reg_idx_t idx);
		logic [31:0] rd;
		logic [31:0] want;
		apb_xfer(1'b0, idx, '0, rd);
		case (idx)
			ashm_pkg::REG_SLEEPING:        want = 32'(cfg_shadow.sleeping);
			ashm_pkg::REG_STUCK_LIMIT:     want = 32'(cfg_shadow.stuck_limit);
			ashm_pkg::REG_OVERRANGE_LIMIT: want = 32'(cfg_shadow.overrange_limit);
			default:                       want = 32'(cfg_shadow.magnitude_limit);
		endcase
		if (rd !== want) begin
			bad_cnt++;
			$display("%0t: register %s expected %0h actual %0h", $time, idx.name(), want, rd);
		end
	endtask

	// Register write, mirrored in the bench copy and read back.
	task automatic cfg_set(input ashm_pkg::reg_idx_t idx, input logic [31:0] val);
		logic [31:0] rd;
		case (idx)
			ashm_pkg::REG_SLEEPING:
				cfg_shadow.sleeping = val[0];
			ashm_pkg::REG_STUCK_LIMIT:
				cfg_shadow.stuck_limit = val[ashm_pkg::COUNT_W-1:0];
			ashm_pkg::REG_OVERRANGE_LIMIT:
				cfg_shadow.overrange_limit = val[ashm_pkg::COUNT_W-1:0];
			default:
				cfg_shadow.magnitude_limit = val[ashm_pkg::SAMPLE_W-1:0];
		endcase
		apb_xfer(1'b1, idx, val, rd);
		reg_check(idx);
	endtask

	task automatic start_phase(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Block idle: nothing queued, nothing offered, no verdict outstanding.
	task automatic wait_idle();
		do @(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	initial begin : main
		int      i;
		int      k;
		int      ph;
		int      send_pcts [4];
		int      recv_pcts [4];
		ashm_pkg::reg_idx_t r;

		send_pcts = '{0, 55, 0, 35};
		recv_pcts = '{0, 0, 55, 35};
		cfg_shadow = '{sleeping: 1'b0, stuck_limit: ashm_pkg::STUCK_LIMIT_RESET,
			overrange_limit: ashm_pkg::OVERRANGE_LIMIT_RESET,
			magnitude_limit: ashm_pkg::MAGNITUDE_LIMIT_RESET};
		for (i = 0; i < ashm_pkg::AXES; i++) begin
			prev_smp[i] = '0;
			same_cnt[i] = '0;
			over_cnt[i] = '0;
			gen_prev[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values of every register.
		r = r.first();
		repeat (4) begin
			reg_check(r);
			r = r.next();
		end

		// Reset limits: all-zero repeats, full-scale codes, partial repeats.
		start_phase(0, 0);
		sample_q.push_back(mk(12'h000, 12'h000, 12'h000));
		sample_q.push_back(mk(12'h800, 12'h7FF, 12'h001));
		sample_q.push_back(mk(12'h800, 12'h123, 12'hFFF));
		sample_q.push_back(mk(12'h800, 12'h123, 12'hFFF));
		sample_q.push_back(mk(12'h000, 12'h000, 12'h000));
		sample_q.push_back(mk(12'h7FF, 12'h800, 12'hFFF));
		wait_idle();

		// Zero limits: any repeat is stuck, every axis is over range.
		cfg_set(ashm_pkg::REG_STUCK_LIMIT, 32'd0);
		cfg_set(ashm_pkg::REG_OVERRANGE_LIMIT, 32'd0);
		cfg_set(ashm_pkg::REG_MAGNITUDE_LIMIT, 32'd0);
		start_phase(0, 0);
		sample_q.push_back(mk(12'h005, 12'h006, 12'h007));
		sample_q.push_back(mk(12'h005, 12'h006, 12'h007));
		sample_q.push_back(mk(12'h000, 12'h000, 12'h000));
		sample_q.push_back(mk(12'h001, 12'h002, 12'h003));
		wait_idle();

		// Magnitude limit at full scale: only the most negative code is over.
		cfg_set(ashm_pkg::REG_STUCK_LIMIT, 32'd2);
		cfg_set(ashm_pkg::REG_OVERRANGE_LIMIT, 32'd1);
		cfg_set(ashm_pkg::REG_MAGNITUDE_LIMIT, 32'd2048);
		start_phase(0, 0);
		sample_q.push_back(mk(12'h800, 12'h7FF, 12'h000));
		sample_q.push_back(mk(12'h7FF, 12'h801, 12'h800));
		sample_q.push_back(mk(12'h800, 12'h800, 12'h800));
		wait_idle();

		// Magnitude limit beyond full scale: nothing is ever over range.
		cfg_set(ashm_pkg::REG_MAGNITUDE_LIMIT, 32'd4095);
		start_phase(0, 0);
		sample_q.push_back(mk(12'h801, 12'h7FE, 12'h801));
		wait_idle();

		// Asleep: verdicts are clear and the state stays as it was.
		cfg_set(ashm_pkg::REG_SLEEPING, 32'd1);
		start_phase(0, 0);
		sample_q.push_back(mk(12'h000, 12'h000, 12'h000));
		sample_q.push_back(mk(12'h801, 12'h7FE, 12'h801));
		sample_q.push_back(mk(12'hABC, 12'h543, 12'h0F0));
		wait_idle();
		cfg_set(ashm_pkg::REG_SLEEPING, 32'd0);
		start_phase(0, 0);
		sample_q.push_back(mk(12'h801, 12'h7FE, 12'h801));
		sample_q.push_back(mk(12'hFFF, 12'hFFF, 12'hFFF));
		wait_idle();

		// Random phases, one per idling pattern, each with its own limits.
		for (ph = 0; ph < 4; ph++) begin
			cfg_set(ashm_pkg::REG_STUCK_LIMIT, ($urandom_range(4) == 0) ?
				$urandom_range(65535) : $urandom_range(6, 1));
			cfg_set(ashm_pkg::REG_OVERRANGE_LIMIT, ($urandom_range(4) == 0) ?
				$urandom_range(65535) : $urandom_range(6, 1));
			cfg_set(ashm_pkg::REG_MAGNITUDE_LIMIT, $urandom_range(2048));
			hold_pct = $urandom_range(40, 10);
			for (i = 0; i < ashm_pkg::AXES; i++)
				gen_prev[i] = prev_smp[i];
			start_phase(send_pcts[ph], recv_pcts[ph]);
			for (k = 0; k < 500; k++) begin
				// Sender holds off until every verdict is back, once.
				if (ph == 1 && k == 250)
					wait_idle();
				sample_q.push_back(draw_sample());
			end
			wait_idle();
		end

		if (bad_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Run limit.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
